// ===== hdl/lca_bl_pkg.sv =====
// Package for the binary-lifting ancestor block: words, codes and defaults.
`default_nettype none

package lca_bl_pkg;

    localparam int NODES_DEF  = 65536;
    localparam int LEVELS_DEF = 16;

    localparam logic [1:0] ACT_LOAD   = 2'd0;
    localparam logic [1:0] ACT_QUERY  = 2'd1;
    localparam logic [1:0] ACT_CLEAR  = 2'd2;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    localparam logic [1:0] STS_OK        = 2'd0;
    localparam logic [1:0] STS_BAD_NODE  = 2'd1;
    localparam logic [1:0] STS_BAD_PAR   = 2'd2;
    localparam logic [1:0] STS_UNLOADED  = 2'd3;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] node_id;
        logic [15:0] parent_id;
        logic [15:0] query_a;
        logic [15:0] query_b;
    } t_in_word;

    typedef struct packed {
        logic [15:0] ancestor;
        logic [1:0]  status;
    } t_out_word;

endpackage

`default_nettype wire

// ===== hdl/lca_bl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module lca_bl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== hdl/lca_binary_lifting.sv =====
// Lowest common ancestor by binary lifting over an ancestor RAM and a node RAM.
// Usage:
//   Input channel i_in_valid / o_in_stall carries one t_in_word: load a node
//   under an already loaded parent, query the common ancestor of two nodes,
//   or clear the tree back to the root alone. Every word gives one result
//   word on o_out_valid / i_out_stall with ancestor and status.
//   Items are handled one at a time; each RAM has one read port with registered
//   read data, and every step of the walk waits on that read.
//   Load: one read and one write per level.
//   Query: one ancestor read per lift step, then descent passes over all levels
//   (two ancestor reads and a compare per level), plus a final ancestor read.
//   Clear: one node-RAM entry swept per cycle.
//   After reset the block sweeps the whole node RAM with the input stalled,
//   leaving only the root loaded.
//   A finished result sits in the output register; the block takes the next
//   input word while it waits, and holds the following result until the
//   receiver drops stall.
`default_nettype none

module lca_binary_lifting
    import lca_bl_pkg::*;
#(
    parameter int NODES  = NODES_DEF,
    parameter int LEVELS = LEVELS_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_word  i_in_word,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_word      o_out_word
);

    localparam int NW = $clog2(NODES);
    localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int AW = NW + LW;
    localparam logic [LW-1:0] LVL_TOP = LW'(LEVELS - 1);

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_SWEEP   = 5'd1;
    localparam logic [4:0] S_LD_N    = 5'd2;
    localparam logic [4:0] S_LD_NCHK = 5'd3;
    localparam logic [4:0] S_LD_PCHK = 5'd4;
    localparam logic [4:0] S_LD_RD   = 5'd5;
    localparam logic [4:0] S_LD_WR   = 5'd6;
    localparam logic [4:0] S_Q_A     = 5'd7;
    localparam logic [4:0] S_Q_B     = 5'd8;
    localparam logic [4:0] S_Q_CHK   = 5'd9;
    localparam logic [4:0] S_LIFT    = 5'd10;
    localparam logic [4:0] S_LIFT_W  = 5'd11;
    localparam logic [4:0] S_DSC_A   = 5'd12;
    localparam logic [4:0] S_DSC_B   = 5'd13;
    localparam logic [4:0] S_DSC_C   = 5'd14;
    localparam logic [4:0] S_FIN     = 5'd15;
    localparam logic [4:0] S_FIN_W   = 5'd16;
    localparam logic [4:0] S_DONE    = 5'd17;

    function automatic logic [NW-1:0] nid(input logic [15:0] id);
        return NW'(id);
    endfunction

    function automatic logic in_range(input logic [15:0] id);
        return 32'(id) < NODES;
    endfunction

    logic [4:0]    r_state, n_state;
    t_in_word      r_in, n_in;
    logic [NW-1:0] r_sw, n_sw;
    logic          r_clr, n_clr;
    logic [15:0]   r_x, n_x;
    logic [15:0]   r_a, n_a;
    logic [15:0]   r_b, n_b;
    logic [15:0]   r_d, n_d;
    logic [15:0]   r_da, n_da;
    logic          r_la, n_la;
    logic [15:0]   r_ua, n_ua;
    logic [LW-1:0] r_lvl, n_lvl;
    logic          r_moved, n_moved;
    t_out_word     r_res, n_res;
    logic          r_ov, n_ov;
    t_out_word     r_out, n_out;
    logic          r_anc_zero;

    // node RAM entry: {loaded, depth}
    logic          node_we;
    logic [NW-1:0] node_waddr, node_raddr;
    logic [16:0]   node_wdata, node_rdata;
    logic          anc_we;
    logic [AW-1:0] anc_waddr, anc_raddr;
    logic [15:0]   anc_wdata, anc_rdata, anc_q;

    logic [LW-1:0] lift_lvl;
    logic          diff;
    logic          mv;

    lca_bl_ram #(.WIDTH(17), .DEPTH(NODES)) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (node_we),
        .i_waddr (node_waddr),
        .i_wdata (node_wdata),
        .i_raddr (node_raddr),
        .o_rdata (node_rdata)
    );

    lca_bl_ram #(.WIDTH(16), .DEPTH(NODES << LW)) u_anc_ram (
        .i_clk   (i_clk),
        .i_we    (anc_we),
        .i_waddr (anc_waddr),
        .i_wdata (anc_wdata),
        .i_raddr (anc_raddr),
        .o_rdata (anc_rdata)
    );

    // the root is its own ancestor at every level
    assign anc_q = r_anc_zero ? 16'd0 : anc_rdata;

    // lift by the highest set bit of the remaining distance, capped at the top level
    always_comb begin
        lift_lvl = '0;
        for (int k = 0; k < 16; k++) begin
            if (r_d[k]) begin
                lift_lvl = (k > LEVELS - 1) ? LVL_TOP : LW'(k);
            end
        end
    end

    assign diff = (anc_q != r_ua);
    assign mv   = r_moved | diff;

    // sequencer
    always_comb begin
        n_state = r_state;
        n_in    = r_in;
        n_sw    = r_sw;
        n_clr   = r_clr;
        n_x     = r_x;
        n_a     = r_a;
        n_b     = r_b;
        n_d     = r_d;
        n_da    = r_da;
        n_la    = r_la;
        n_ua    = r_ua;
        n_lvl   = r_lvl;
        n_moved = r_moved;
        n_res   = r_res;
        n_ov    = r_ov & i_out_stall;
        n_out   = r_out;

        node_we    = 1'b0;
        node_waddr = r_sw;
        node_wdata = '0;
        node_raddr = '0;
        anc_we     = 1'b0;
        anc_waddr  = '0;
        anc_wdata  = '0;
        anc_raddr  = '0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_in = i_in_word;
                    n_res = '{ancestor: 16'd0, status: STS_OK};
                    case (i_in_word.action)
                        ACT_LOAD: begin
                            if (i_in_word.node_id == 16'd0 || !in_range(i_in_word.node_id)) begin
                                n_res.status = STS_BAD_NODE;
                                n_state = S_DONE;
                            end else begin
                                n_state = S_LD_N;
                            end
                        end
                        ACT_QUERY: begin
                            if (!in_range(i_in_word.query_a) || !in_range(i_in_word.query_b)) begin
                                n_res.status = STS_UNLOADED;
                                n_state = S_DONE;
                            end else begin
                                n_state = S_Q_A;
                            end
                        end
                        ACT_CLEAR: begin
                            n_sw = '0;
                            n_clr = 1'b1;
                            n_state = S_SWEEP;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_SWEEP: begin
                node_we = 1'b1;
                node_waddr = r_sw;
                node_wdata = {(r_sw == '0), 16'd0};
                n_sw = r_sw + 1'b1;
                if (r_sw == NW'(NODES - 1)) begin
                    n_state = r_clr ? S_DONE : S_IDLE;
                end
            end
            S_LD_N: begin
                node_raddr = nid(r_in.node_id);
                n_state = S_LD_NCHK;
            end
            S_LD_NCHK: begin
                if (node_rdata[16]) begin
                    n_res.status = STS_BAD_NODE;
                    n_state = S_DONE;
                end else if (r_in.parent_id >= r_in.node_id) begin
                    n_res.status = STS_BAD_PAR;
                    n_state = S_DONE;
                end else begin
                    node_raddr = nid(r_in.parent_id);
                    n_state = S_LD_PCHK;
                end
            end
            S_LD_PCHK: begin
                if (!node_rdata[16]) begin
                    n_res.status = STS_BAD_PAR;
                    n_state = S_DONE;
                end else begin
                    node_we = 1'b1;
                    node_waddr = nid(r_in.node_id);
                    node_wdata = {1'b1, node_rdata[15:0] + 16'd1};
                    anc_we = 1'b1;
                    anc_waddr = {nid(r_in.node_id), LW'(0)};
                    anc_wdata = r_in.parent_id;
                    n_x = r_in.parent_id;
                    n_lvl = '0;
                    n_state = (LEVELS == 1) ? S_DONE : S_LD_RD;
                end
            end
            S_LD_RD: begin
                anc_raddr = {nid(r_x), r_lvl};
                n_state = S_LD_WR;
            end
            S_LD_WR: begin
                anc_we = 1'b1;
                anc_waddr = {nid(r_in.node_id), r_lvl + 1'b1};
                anc_wdata = anc_q;
                n_x = anc_q;
                n_lvl = r_lvl + 1'b1;
                n_state = (32'(r_lvl) + 1 == LEVELS - 1) ? S_DONE : S_LD_RD;
            end
            S_Q_A: begin
                node_raddr = nid(r_in.query_a);
                n_state = S_Q_B;
            end
            S_Q_B: begin
                n_la = node_rdata[16];
                n_da = node_rdata[15:0];
                node_raddr = nid(r_in.query_b);
                n_state = S_Q_CHK;
            end
            S_Q_CHK: begin
                if (!r_la || !node_rdata[16]) begin
                    n_res.status = STS_UNLOADED;
                    n_state = S_DONE;
                end else begin
                    // keep the shallower node in a
                    if (r_da > node_rdata[15:0]) begin
                        n_a = r_in.query_b;
                        n_b = r_in.query_a;
                        n_d = r_da - node_rdata[15:0];
                    end else begin
                        n_a = r_in.query_a;
                        n_b = r_in.query_b;
                        n_d = node_rdata[15:0] - r_da;
                    end
                    n_state = S_LIFT;
                end
            end
            S_LIFT: begin
                if (r_d == 16'd0) begin
                    if (r_a == r_b) begin
                        n_res.ancestor = r_a;
                        n_state = S_DONE;
                    end else begin
                        n_lvl = LVL_TOP;
                        n_moved = 1'b0;
                        n_state = S_DSC_A;
                    end
                end else begin
                    anc_raddr = {nid(r_b), lift_lvl};
                    n_d = r_d - (16'd1 << lift_lvl);
                    n_state = S_LIFT_W;
                end
            end
            S_LIFT_W: begin
                n_b = anc_q;
                n_state = S_LIFT;
            end
            S_DSC_A: begin
                anc_raddr = {nid(r_a), r_lvl};
                n_state = S_DSC_B;
            end
            S_DSC_B: begin
                n_ua = anc_q;
                anc_raddr = {nid(r_b), r_lvl};
                n_state = S_DSC_C;
            end
            S_DSC_C: begin
                if (diff) begin
                    n_a = r_ua;
                    n_b = anc_q;
                end
                if (r_lvl == '0) begin
                    n_moved = 1'b0;
                    if (mv) begin
                        n_lvl = LVL_TOP;
                        n_state = S_DSC_A;
                    end else begin
                        n_state = S_FIN;
                    end
                end else begin
                    n_lvl = r_lvl - 1'b1;
                    n_moved = mv;
                    n_state = S_DSC_A;
                end
            end
            S_FIN: begin
                anc_raddr = {nid(r_a), LW'(0)};
                n_state = S_FIN_W;
            end
            S_FIN_W: begin
                n_res.ancestor = anc_q;
                n_state = S_DONE;
            end
            S_DONE: begin
                // hand the result over once the output register is free
                if (!r_ov || !i_out_stall) begin
                    n_ov = 1'b1;
                    n_out = r_res;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_SWEEP;
            r_sw    <= '0;
            r_clr   <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sw    <= n_sw;
            r_clr   <= n_clr;
            r_ov    <= n_ov;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_in       <= n_in;
        r_x        <= n_x;
        r_a        <= n_a;
        r_b        <= n_b;
        r_d        <= n_d;
        r_da       <= n_da;
        r_la       <= n_la;
        r_ua       <= n_ua;
        r_lvl      <= n_lvl;
        r_moved    <= n_moved;
        r_res      <= n_res;
        r_out      <= n_out;
        r_anc_zero <= (anc_raddr[AW-1:LW] == '0);
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ov;
    assign o_out_word  = r_out;

endmodule

`default_nettype wire
